### src/rrpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrpa_pkg
// Shared widths, constants and types of the rainy-run pressure averager.
// ----------------------------------------------------------------------------
package rrpa_pkg;

  localparam int COUNT_BITS    = 16;
  localparam int PRESSURE_BITS = 14;
  localparam int STATION_BITS  = 32;
  localparam int HOUR_BITS     = 5;
  localparam int RAIN_BITS     = 16;

  // Sum of up to 2^COUNT_BITS-1 pressures, plus the rounding term, fits here
  localparam int SUM_BITS  = COUNT_BITS + PRESSURE_BITS;
  localparam int STEP_BITS = $clog2(SUM_BITS + 1);

  localparam logic [RAIN_BITS-1:0]  THRESH_RESET = RAIN_BITS'(100);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX    = {COUNT_BITS{1'b1}};

  // Sequencer states of the top level
  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } state_t;

  // Open-run bookkeeping handed from the accumulator to the top level
  typedef struct packed {
    logic                     in_run;
    logic [STATION_BITS-1:0]  station;
    logic [HOUR_BITS-1:0]     hour;
    logic [PRESSURE_BITS-1:0] prior;
    logic [SUM_BITS-1:0]      sum;
    logic [COUNT_BITS-1:0]    count;
    logic                     overflow;
  } run_t;

endpackage

### src/rrpa_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrpa_accum
// Classifies each accepted word as rainy or dry and keeps the open run:
// latched station, hour and prior pressure, pressure sum and sample count.
// ----------------------------------------------------------------------------
module rrpa_accum
  import rrpa_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     accept,
  input  logic [STATION_BITS-1:0]  station_code,
  input  logic [HOUR_BITS-1:0]     hour_of_day,
  input  logic [RAIN_BITS-1:0]     rain_amount,
  input  logic [PRESSURE_BITS-1:0] pressure,
  input  logic [RAIN_BITS-1:0]     threshold,
  output run_t                     run,
  output logic                     close
);

  run_t                     run_r, run_nxt;
  logic [PRESSURE_BITS-1:0] prev_r, prev_nxt;
  logic                     rainy;

  assign rainy = rain_amount > threshold;
  assign close = accept && !rainy && run_r.in_run;
  assign run   = run_r;

  // Open, extend or close the run; track the last pressure seen
  always_comb begin
    run_nxt  = run_r;
    prev_nxt = prev_r;
    if (accept) begin
      prev_nxt = pressure;
      if (rainy) begin
        if (!run_r.in_run) begin
          run_nxt.in_run   = 1'b1;
          run_nxt.station  = station_code;
          run_nxt.hour     = hour_of_day;
          run_nxt.prior    = prev_r;
          run_nxt.sum      = SUM_BITS'(pressure);
          run_nxt.count    = COUNT_BITS'(1);
          run_nxt.overflow = 1'b0;
        end else if (run_r.count == COUNT_MAX) begin
          run_nxt.overflow = 1'b1;
        end else begin
          run_nxt.sum   = run_r.sum + SUM_BITS'(pressure);
          run_nxt.count = run_r.count + COUNT_BITS'(1);
        end
      end else begin
        // sum, count and latches stay put until the mean is taken
        run_nxt.in_run = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= '0;
      prev_r <= '0;
    end else begin
      run_r  <= run_nxt;
      prev_r <= prev_nxt;
    end
  end

endmodule

### src/rrpa_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrpa_div
// Bit-serial restoring divider: the dividend shifts out of a shift register
// one bit per cycle while quotient bits shift in behind it.
// ----------------------------------------------------------------------------
module rrpa_div
  import rrpa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [SUM_BITS-1:0]   dividend,
  input  logic [COUNT_BITS-1:0] divisor,
  output logic                  done,
  output logic [SUM_BITS-1:0]   quotient
);

  logic [SUM_BITS-1:0]   quo_r, quo_nxt;
  logic [COUNT_BITS:0]   rem_r, rem_nxt;
  logic [COUNT_BITS-1:0] dvs_r, dvs_nxt;
  logic [STEP_BITS-1:0]  step_r, step_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [COUNT_BITS:0]   rem_sh;
  logic [COUNT_BITS+1:0] diff;
  logic                  ge;

  // One quotient bit per cycle: shift, trial subtract, keep or restore
  assign rem_sh = {rem_r[COUNT_BITS-1:0], quo_r[SUM_BITS-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs_r};
  assign ge     = !diff[COUNT_BITS+1];

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      step_nxt = '0;
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      quo_nxt  = {quo_r[SUM_BITS-2:0], ge};
      rem_nxt  = ge ? diff[COUNT_BITS:0] : rem_sh;
      step_nxt = step_r + STEP_BITS'(1);
      if (step_r == STEP_BITS'(SUM_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  // Datapath shift registers
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### src/rain_run_pressure_averager.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rain_run_pressure_averager
// Groups consecutive rainy hourly samples into runs and reports, for each
// run, its start, length, surrounding pressures and rounded mean pressure.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (station, hour, rain, pressure) arrive on in_valid/in_ready;
//   result words leave on out_valid/out_ready. cfg_wr_en with cfg_wr_data
//   sets the rain threshold (reset 100) and is taken in the same cycle.
//   A word that opens, extends or does not touch a run is absorbed and
//   in_ready stays high. The dry word that closes a run starts a serial
//   divider for the mean: one quotient bit per cycle over the
//   COUNT_BITS+PRESSURE_BITS = 30 bit dividend. in_ready stays low until
//   the finished mean has been loaded into the output register.
//   The result sits in an output register; further words that give no
//   result keep being taken while out_valid waits for out_ready. If a new
//   mean is finished while the old result still waits, it holds in the
//   divider and the input stays stalled until the receiver takes the word.
//   Synchronous reset clears the run, the prior pressure (reads 0 before
//   the first sample), the output valid and sets the threshold to 100.
// ----------------------------------------------------------------------------
module rain_run_pressure_averager
  import rrpa_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [STATION_BITS-1:0]  in_station_code,
  input  logic [HOUR_BITS-1:0]     in_hour_of_day,
  input  logic [RAIN_BITS-1:0]     in_rain_amount,
  input  logic [PRESSURE_BITS-1:0] in_pressure,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [STATION_BITS-1:0]  out_run_station,
  output logic [HOUR_BITS-1:0]     out_run_start_hour,
  output logic [COUNT_BITS-1:0]    out_run_length,
  output logic [PRESSURE_BITS-1:0] out_pressure_before,
  output logic [PRESSURE_BITS-1:0] out_pressure_mean,
  output logic [PRESSURE_BITS-1:0] out_pressure_after,
  output logic                     out_length_saturated,
  input  logic                     cfg_wr_en,
  input  logic [RAIN_BITS-1:0]     cfg_wr_data
);

  state_t                   state_r, state_nxt;
  logic [RAIN_BITS-1:0]     thresh_r;
  logic [PRESSURE_BITS-1:0] after_r, after_nxt;
  logic                     ovalid_r, ovalid_nxt;
  logic                     load_out;
  logic                     accept;
  logic                     close;
  logic                     div_start;
  logic                     div_done;
  logic [SUM_BITS-1:0]      dividend;
  logic [SUM_BITS-1:0]      quotient;
  run_t                     run;

  logic [STATION_BITS-1:0]  station_r;
  logic [HOUR_BITS-1:0]     hour_r;
  logic [COUNT_BITS-1:0]    length_r;
  logic [PRESSURE_BITS-1:0] prior_r;
  logic [PRESSURE_BITS-1:0] mean_r;
  logic [PRESSURE_BITS-1:0] oafter_r;
  logic                     sat_r;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  rrpa_accum u_accum (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .station_code (in_station_code),
    .hour_of_day  (in_hour_of_day),
    .rain_amount  (in_rain_amount),
    .pressure     (in_pressure),
    .threshold    (thresh_r),
    .run          (run),
    .close        (close)
  );

  // Round to nearest: add half the count before dividing
  assign dividend  = run.sum + SUM_BITS'(run.count >> 1);
  assign div_start = close;

  rrpa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (run.count),
    .done     (div_done),
    .quotient (quotient)
  );

  // Threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
    end else if (cfg_wr_en) begin
      thresh_r <= cfg_wr_data;
    end
  end

  // Sequence: absorb words, divide on close, hand the result to the output
  always_comb begin
    state_nxt  = state_r;
    after_nxt  = after_r;
    ovalid_nxt = ovalid_r;
    load_out   = 1'b0;
    if (ovalid_r && out_ready) begin
      ovalid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (close) begin
          after_nxt = in_pressure;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done && (!ovalid_r || out_ready)) begin
          load_out   = 1'b1;
          ovalid_nxt = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    after_r <= after_nxt;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      station_r <= run.station;
      hour_r    <= run.hour;
      length_r  <= run.count;
      prior_r   <= run.prior;
      mean_r    <= quotient[PRESSURE_BITS-1:0];
      oafter_r  <= after_r;
      sat_r     <= run.overflow;
    end
  end

  assign out_valid            = ovalid_r;
  assign out_run_station      = station_r;
  assign out_run_start_hour   = hour_r;
  assign out_run_length       = length_r;
  assign out_pressure_before  = prior_r;
  assign out_pressure_mean    = mean_r;
  assign out_pressure_after   = oafter_r;
  assign out_length_saturated = sat_r;

endmodule

### tb/rrpa_run_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrpa_run_checker
// Watches the sample channel, the result channel and the threshold port of
// the rainy-run pressure averager. It keeps its own run bookkeeping, predicts
// one summary per closed run and checks each result word against the oldest
// prediction, field by field.
// ----------------------------------------------------------------------------
module rrpa_run_checker
  import rrpa_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [STATION_BITS-1:0]  in_station_code,
  input  logic [HOUR_BITS-1:0]     in_hour_of_day,
  input  logic [RAIN_BITS-1:0]     in_rain_amount,
  input  logic [PRESSURE_BITS-1:0] in_pressure,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [STATION_BITS-1:0]  out_run_station,
  input  logic [HOUR_BITS-1:0]     out_run_start_hour,
  input  logic [COUNT_BITS-1:0]    out_run_length,
  input  logic [PRESSURE_BITS-1:0] out_pressure_before,
  input  logic [PRESSURE_BITS-1:0] out_pressure_mean,
  input  logic [PRESSURE_BITS-1:0] out_pressure_after,
  input  logic                     out_length_saturated,
  input  logic                     cfg_wr_en,
  input  logic [RAIN_BITS-1:0]     cfg_wr_data,
  output int                       fail_count,
  output int                       open_results
);

  typedef struct packed {
    logic [STATION_BITS-1:0]  station;
    logic [HOUR_BITS-1:0]     start_hour;
    logic [COUNT_BITS-1:0]    length;
    logic [PRESSURE_BITS-1:0] prior;
    logic [PRESSURE_BITS-1:0] mean;
    logic [PRESSURE_BITS-1:0] after;
    logic                     saturated;
  } run_summary_t;

  // Summaries of closed runs whose result word has not left yet
  run_summary_t expected_runs[$];

  // Predicted state of the block
  logic [RAIN_BITS-1:0]     rain_limit;
  logic                     in_run;
  logic [PRESSURE_BITS-1:0] last_pressure;
  logic [63:0]              run_sum;
  logic [COUNT_BITS-1:0]    run_count;
  logic [PRESSURE_BITS-1:0] held_prior;
  logic [HOUR_BITS-1:0]     held_hour;
  logic [STATION_BITS-1:0]  held_station;
  logic                     run_overflow;

  initial begin
    fail_count   = 0;
    open_results = 0;
  end

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    fail_count++;
    $display("[%0t] mismatch in %s: got %0d, want %0d", $time, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      flag_mismatch(what, got, want);
    end
  endtask

  // Fold one accepted sample into the run bookkeeping; queue a summary
  // when a dry word closes an open run
  task automatic fold_sample(input logic [STATION_BITS-1:0]  station,
                             input logic [HOUR_BITS-1:0]     hour,
                             input logic [RAIN_BITS-1:0]     rain,
                             input logic [PRESSURE_BITS-1:0] pres);
    run_summary_t summary;
    logic [63:0]  divisor;
    if (rain > rain_limit) begin
      if (!in_run) begin
        // open a run and latch its head
        in_run       = 1'b1;
        held_station = station;
        held_hour    = hour;
        held_prior   = last_pressure;
        run_sum      = 64'(pres);
        run_count    = COUNT_BITS'(1);
        run_overflow = 1'b0;
      end else if (run_count == COUNT_MAX) begin
        // counter full: drop the sample, remember it
        run_overflow = 1'b1;
      end else begin
        run_sum   = run_sum + 64'(pres);
        run_count = run_count + 1'b1;
      end
    end else if (in_run) begin
      // close the run: rounded mean, ties up
      divisor              = (run_count == 0) ? 64'd1 : 64'(run_count);
      summary.station      = held_station;
      summary.start_hour   = held_hour;
      summary.length       = run_count;
      summary.prior        = held_prior;
      summary.mean         = PRESSURE_BITS'((run_sum + (divisor >> 1)) / divisor);
      summary.after        = pres;
      summary.saturated    = run_overflow;
      expected_runs.push_back(summary);
      in_run       = 1'b0;
      run_sum      = '0;
      run_count    = '0;
      run_overflow = 1'b0;
    end
    last_pressure = pres;
  endtask

  // Match result words first: a word leaving now never comes from a
  // sample taken at the same edge
  always @(posedge clk) begin : watch
    run_summary_t want;
    if (!rst_n) begin
      rain_limit    = THRESH_RESET;
      in_run        = 1'b0;
      last_pressure = '0;
      run_sum       = '0;
      run_count     = '0;
      held_prior    = '0;
      held_hour     = '0;
      held_station  = '0;
      run_overflow  = 1'b0;
      expected_runs.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_runs.size() == 0) begin
          flag_mismatch("result word with no closed run", out_run_length, 0);
        end else begin
          want = expected_runs.pop_front();
          check_field("run_station", out_run_station, want.station);
          check_field("run_start_hour", out_run_start_hour, want.start_hour);
          check_field("run_length", out_run_length, want.length);
          check_field("pressure_before", out_pressure_before, want.prior);
          check_field("pressure_mean", out_pressure_mean, want.mean);
          check_field("pressure_after", out_pressure_after, want.after);
          check_field("length_saturated", out_length_saturated, want.saturated);
        end
      end
      if (in_valid && in_ready) begin
        fold_sample(in_station_code, in_hour_of_day, in_rain_amount, in_pressure);
      end
      if (cfg_wr_en) begin
        rain_limit = cfg_wr_data;
      end
    end
    open_results = expected_runs.size();
  end

endmodule

### tb/rain_run_pressure_averager_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rain_run_pressure_averager_tb
// Drives hourly samples into the rainy-run pressure averager: directed edge
// cases first, then phases of random rain runs under several thresholds and
// idle/stall mixes, and a long receiver hold-off. A checker beside the
// block predicts and compares results.
// ----------------------------------------------------------------------------
module rain_run_pressure_averager_tb;
  import rrpa_pkg::*;

  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_WORDS   = 280;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [STATION_BITS-1:0]  in_station_code;
  logic [HOUR_BITS-1:0]     in_hour_of_day;
  logic [RAIN_BITS-1:0]     in_rain_amount;
  logic [PRESSURE_BITS-1:0] in_pressure;
  logic                     out_valid;
  logic                     out_ready;
  logic [STATION_BITS-1:0]  out_run_station;
  logic [HOUR_BITS-1:0]     out_run_start_hour;
  logic [COUNT_BITS-1:0]    out_run_length;
  logic [PRESSURE_BITS-1:0] out_pressure_before;
  logic [PRESSURE_BITS-1:0] out_pressure_mean;
  logic [PRESSURE_BITS-1:0] out_pressure_after;
  logic                     out_length_saturated;
  logic                     cfg_wr_en;
  logic [RAIN_BITS-1:0]     cfg_wr_data;

  int                   fail_count;
  int                   open_results;
  int                   idle_pct     = 0;
  int                   stall_pct    = 0;
  bit                   hold_req     = 1'b0;
  int                   quiet_cycles = 0;
  logic [RAIN_BITS-1:0] rain_limit;

  rain_run_pressure_averager dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_station_code      (in_station_code),
    .in_hour_of_day       (in_hour_of_day),
    .in_rain_amount       (in_rain_amount),
    .in_pressure          (in_pressure),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_run_station      (out_run_station),
    .out_run_start_hour   (out_run_start_hour),
    .out_run_length       (out_run_length),
    .out_pressure_before  (out_pressure_before),
    .out_pressure_mean    (out_pressure_mean),
    .out_pressure_after   (out_pressure_after),
    .out_length_saturated (out_length_saturated),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data)
  );

  rrpa_run_checker checker_i (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_station_code      (in_station_code),
    .in_hour_of_day       (in_hour_of_day),
    .in_rain_amount       (in_rain_amount),
    .in_pressure          (in_pressure),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_run_station      (out_run_station),
    .out_run_start_hour   (out_run_start_hour),
    .out_run_length       (out_run_length),
    .out_pressure_before  (out_pressure_before),
    .out_pressure_mean    (out_pressure_mean),
    .out_pressure_after   (out_pressure_after),
    .out_length_saturated (out_length_saturated),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .fail_count           (fail_count),
    .open_results         (open_results)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side: random stalls, or a long hold-off counted here
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // End the run when no word moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("rain_run_pressure_averager verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [HOUR_BITS-1:0] pick_hour();
    if ($urandom_range(7) == 0) begin
      return HOUR_BITS'($urandom_range(31, 0));
    end
    return HOUR_BITS'($urandom_range(23, 0));
  endfunction

  function automatic logic [PRESSURE_BITS-1:0] pick_pressure();
    case ($urandom_range(15))
      0: return '0;
      1: return '1;
      default: return PRESSURE_BITS'($urandom_range(16383, 0));
    endcase
  endfunction

  // Rain strictly above the current threshold
  function automatic logic [RAIN_BITS-1:0] wet_rain();
    case ($urandom_range(9))
      0: return '1;
      1: return rain_limit + 1'b1;
      default: return RAIN_BITS'($urandom_range(65535, rain_limit + 1));
    endcase
  endfunction

  // Rain at or below the current threshold
  function automatic logic [RAIN_BITS-1:0] dry_rain();
    case ($urandom_range(9))
      0: return '0;
      1: return rain_limit;
      default: return RAIN_BITS'($urandom_range(rain_limit, 0));
    endcase
  endfunction

  // Offer one sample word after a random idle gap; hold it until taken
  task automatic offer_sample(input logic [STATION_BITS-1:0]  station,
                              input logic [HOUR_BITS-1:0]     hour,
                              input logic [RAIN_BITS-1:0]     rain,
                              input logic [PRESSURE_BITS-1:0] pres);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_station_code <= station;
    in_hour_of_day  <= hour;
    in_rain_amount  <= rain;
    in_pressure     <= pres;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid, drain all pending results, then let the block sit idle
  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (open_results != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_rain_threshold(input logic [RAIN_BITS-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    rain_limit  = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly well-formed runs (wet words, then dry ones), some noise words
  task automatic random_weather(input int target);
    int sent;
    int run_len;
    int dry_len;
    int k;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(19) == 0) begin
        offer_sample($urandom(), HOUR_BITS'($urandom_range(31, 0)),
                     RAIN_BITS'($urandom_range(65535, 0)), pick_pressure());
        sent++;
      end else begin
        case ($urandom_range(49))
          0:                 run_len = $urandom_range(120, 41);
          1, 2, 3, 4, 5, 6:  run_len = $urandom_range(20, 7);
          default:           run_len = $urandom_range(6, 1);
        endcase
        dry_len = $urandom_range(3, 1);
        for (k = 0; k < run_len; k++) begin
          offer_sample($urandom(), pick_hour(), wet_rain(), pick_pressure());
        end
        for (k = 0; k < dry_len; k++) begin
          offer_sample($urandom(), pick_hour(), dry_rain(), pick_pressure());
        end
        sent += run_len + dry_len;
      end
    end
  endtask

  initial begin : stimulus
    int phase;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_station_code = '0;
    in_hour_of_day  = '0;
    in_rain_amount  = '0;
    in_pressure     = '0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    rain_limit      = THRESH_RESET;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Reset threshold: a wet first word sees pressure before as zero
    offer_sample(32'hFFFF_FFFF, 5'd0, 16'd101, 14'h3FFF);
    offer_sample(32'h0000_0000, 5'd23, 16'hFFFF, 14'd0);
    // rain equal to the threshold is dry and closes the run
    offer_sample(32'h5254_4E31, 5'd5, 16'd100, 14'd0);
    // dry word outside a run only moves the prior pressure
    offer_sample(32'hAAAA_5555, 5'd1, 16'd0, 14'd5);
    // hours past 23 pass through
    offer_sample(32'h5555_AAAA, 5'd31, 16'd200, 14'd7);
    offer_sample(32'h1234_5678, 5'd24, 16'd150, 14'd9);
    offer_sample(32'h8765_4321, 5'd2, 16'd0, 14'h3FFF);
    // half-way mean rounds up
    offer_sample(32'h0F0F_F0F0, 5'd3, 16'd101, 14'd1);
    offer_sample(32'h0F0F_F0F0, 5'd4, 16'd101, 14'd2);
    offer_sample(32'h0F0F_F0F0, 5'd5, 16'd0, 14'd3);
    // below half-way rounds down
    offer_sample(32'hC3C3_3C3C, 5'd16, 16'h8000, 14'd1);
    offer_sample(32'hC3C3_3C3C, 5'd17, 16'h7FFF, 14'd1);
    offer_sample(32'hC3C3_3C3C, 5'd18, 16'd1000, 14'd2);
    offer_sample(32'hC3C3_3C3C, 5'd19, 16'd99, 14'h2AAA);

    // Lowest threshold: only zero rain is dry; leave one run open
    settle_block();
    set_rain_threshold(16'd0);
    offer_sample(32'h0000_0001, 5'd8, 16'd0, 14'h1555);
    offer_sample(32'h0000_0002, 5'd9, 16'd1, 14'd100);
    offer_sample(32'h0000_0003, 5'd10, 16'd0, 14'd200);
    offer_sample(32'h0000_0004, 5'd11, 16'd1, 14'd300);

    // Highest threshold: nothing is wet, first dry word closes the open run
    settle_block();
    set_rain_threshold(16'hFFFF);
    offer_sample(32'h0000_0005, 5'd12, 16'hFFFF, 14'd400);
    offer_sample(32'h0000_0006, 5'd13, 16'hFFFF, 14'd500);
    offer_sample(32'h0000_0007, 5'd14, 16'd0, 14'd600);

    // Random phases: threshold and idle/stall mix per phase
    for (phase = 0; phase < 4; phase++) begin
      settle_block();
      case (phase)
        0: begin
          idle_pct = 0;  stall_pct = 0;
          set_rain_threshold(16'd0);
        end
        1: begin
          idle_pct = 76; stall_pct = 0;
          set_rain_threshold(RAIN_BITS'($urandom_range(65534, 0)));
        end
        2: begin
          idle_pct = 0;  stall_pct = 76;
          set_rain_threshold(16'd100);
        end
        default: begin
          idle_pct = 6;  stall_pct = 6;
          set_rain_threshold(RAIN_BITS'($urandom_range(65534, 60000)));
        end
      endcase
      random_weather(PHASE_WORDS);
    end

    // Hold off the receiver while samples keep coming, so the block backs up
    settle_block();
    idle_pct  = 0;
    stall_pct = 0;
    set_rain_threshold(RAIN_BITS'($urandom_range(2000, 0)));
    hold_req = 1'b1;
    random_weather(80);
    // runs after a hold-off start clean
    random_weather(40);

    settle_block();
    if (fail_count == 0 && open_results == 0) begin
      $display("rain_run_pressure_averager verification clean");
    end else begin
      $display("rain_run_pressure_averager verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
src/rrpa_pkg.sv
src/rrpa_accum.sv
src/rrpa_div.sv
src/rain_run_pressure_averager.sv
tb/rrpa_run_checker.sv
tb/rain_run_pressure_averager_tb.sv
